/* rtl/bdq_pkg.sv */
// Shared types and constants for the bounded deque.
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int WORD_W       = 32;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

endpackage

`default_nettype wire

/* rtl/bdq_ram.sv */
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/bounded_deque_top.sv */
// Top level of the bounded deque: pointer control around one ring RAM.
//
// Usage: a command item (in_cmd, in_value) is taken at a rising edge where
// start is high and busy is low. busy stays low, so a command can be issued
// in every cycle. Each command gives exactly one result in the next cycle:
// out_valid is high for one cycle with out_status, out_popped and
// out_occupancy (words stored after that command). Throughput is one item
// per cycle, set by the single RAM port: each command makes at most one
// access (a write for a push, a read for a pop), and pointers and count
// update at the accepting edge, so the next command sees them at once.
// Results are registered, and pop data comes from the registered RAM read.
// A push into a full deque reports full and stores nothing; a pop from an
// empty deque reports empty with out_popped zero.
// Reset (rst_n low, synchronous) clears the pointers, the count and the
// result strobe; the RAM contents are not cleared and need no sweep.
// The receiver cannot stall: each result is presented for one cycle only.
`timescale 1ns / 1ps
`default_nettype none

module bounded_deque_top #(
  parameter int CAPACITY = bdq_pkg::CAPACITY_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire bdq_pkg::cmd_t                   in_cmd,
  input  wire logic signed [bdq_pkg::WORD_W-1:0] in_value,
  output logic                                 out_valid,
  output bdq_pkg::status_t                     out_status,
  output logic signed [bdq_pkg::WORD_W-1:0]    out_popped,
  output logic [$clog2(CAPACITY+1)-1:0]        out_occupancy
);

  import bdq_pkg::*;

  localparam int PTR_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  logic [PTR_W-1:0]  front_r, front_nxt;
  logic [PTR_W-1:0]  back_r, back_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              valid_r, valid_nxt;
  status_t           status_r, status_nxt;
  logic              pop_ok_r, pop_ok_nxt;

  logic              accept;
  logic [PTR_W-1:0]  front_prev, front_next, back_prev, back_next;
  logic              ram_en, ram_we;
  logic [PTR_W-1:0]  ram_addr;
  logic [WORD_W-1:0] ram_rdata;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign front_prev = (front_r == '0) ? PTR_LAST : front_r - PTR_W'(1);
  assign front_next = (front_r == PTR_LAST) ? '0 : front_r + PTR_W'(1);
  assign back_prev  = (back_r == '0) ? PTR_LAST : back_r - PTR_W'(1);
  assign back_next  = (back_r == PTR_LAST) ? '0 : back_r + PTR_W'(1);

  always_comb begin
    front_nxt  = front_r;
    back_nxt   = back_r;
    count_nxt  = count_r;
    valid_nxt  = accept;
    status_nxt = ST_OK;
    pop_ok_nxt = 1'b0;
    ram_en     = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = front_r;
    if (accept) begin
      unique case (in_cmd)
        CMD_PUSH_FRONT: begin
          if (count_r == CNT_FULL) begin
            status_nxt = ST_FULL;
          end else begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = front_prev;
            front_nxt = front_prev;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        CMD_PUSH_BACK: begin
          if (count_r == CNT_FULL) begin
            status_nxt = ST_FULL;
          end else begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = back_r;
            back_nxt  = back_next;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        CMD_POP_FRONT: begin
          if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            ram_en     = 1'b1;
            ram_addr   = front_r;
            front_nxt  = front_next;
            count_nxt  = count_r - CNT_W'(1);
            pop_ok_nxt = 1'b1;
          end
        end
        CMD_POP_BACK: begin
          if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            ram_en     = 1'b1;
            ram_addr   = back_prev;
            back_nxt   = back_prev;
            count_nxt  = count_r - CNT_W'(1);
            pop_ok_nxt = 1'b1;
          end
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r  <= '0;
      back_r   <= '0;
      count_r  <= '0;
      valid_r  <= 1'b0;
      pop_ok_r <= 1'b0;
    end else begin
      front_r  <= front_nxt;
      back_r   <= back_nxt;
      count_r  <= count_nxt;
      valid_r  <= valid_nxt;
      pop_ok_r <= pop_ok_nxt;
    end
  end

  // status is payload; it is only looked at under out_valid
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
  end

  bdq_ram #(
    .WIDTH(WORD_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(in_value),
    .rdata(ram_rdata)
  );

  assign out_valid     = valid_r;
  assign out_status    = status_r;
  assign out_popped    = pop_ok_r ? ram_rdata : '0;
  // count_r already holds the occupancy after the command being reported
  assign out_occupancy = count_r;

endmodule

`default_nettype wire

/* bench/bounded_deque_top_tb.sv */
// Self-checking testbench for the bounded deque: directed end cases, then random command streams.
`timescale 1ns / 1ps

module bounded_deque_top_tb;
  import bdq_pkg::*;

  localparam int DEPTH   = CAPACITY_DEF;
  localparam int OCC_W   = $clog2(DEPTH + 1);
  localparam int MAX_GAP = 11;

  typedef struct {
    status_t              status;
    logic signed [31:0]   popped;
    logic [OCC_W-1:0]     occupancy;
  } deque_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  cmd_t                 in_cmd;
  logic signed [31:0]   in_value;
  logic                 out_valid;
  status_t              out_status;
  logic signed [31:0]   out_popped;
  logic [OCC_W-1:0]     out_occupancy;

  // Shadow copy of the deque contents and pointers.
  logic [31:0]          shadow_word [DEPTH];
  int                   shadow_head;
  int                   shadow_tail;
  int                   shadow_fill;

  deque_result_t        pending_results[$];
  int                   mismatch_count;
  bit                   sender_idles;

  bounded_deque_top #(.CAPACITY(DEPTH)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_popped    (out_popped),
    .out_occupancy (out_occupancy)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: MISMATCH %s: got 0x%08h, expected 0x%08h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Update the shadow deque for one accepted command and queue its result.
  task automatic apply_deque_cmd(input cmd_t c, input logic [31:0] v);
    deque_result_t r;
    r.status = ST_OK;
    r.popped = '0;
    case (c)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (shadow_fill >= DEPTH) begin
          r.status = ST_FULL;
        end else if (c == CMD_PUSH_FRONT) begin
          shadow_head = (shadow_head == 0) ? DEPTH - 1 : shadow_head - 1;
          shadow_word[shadow_head] = v;
          shadow_fill++;
        end else begin
          shadow_word[shadow_tail] = v;
          shadow_tail = (shadow_tail == DEPTH - 1) ? 0 : shadow_tail + 1;
          shadow_fill++;
        end
      end
      default: begin
        if (shadow_fill == 0) begin
          r.status = ST_EMPTY;
        end else if (c == CMD_POP_FRONT) begin
          r.popped = shadow_word[shadow_head];
          shadow_head = (shadow_head == DEPTH - 1) ? 0 : shadow_head + 1;
          shadow_fill--;
        end else begin
          shadow_tail = (shadow_tail == 0) ? DEPTH - 1 : shadow_tail - 1;
          r.popped = shadow_word[shadow_tail];
          shadow_fill--;
        end
      end
    endcase
    r.occupancy = shadow_fill[OCC_W-1:0];
    pending_results.push_back(r);
  endtask

  // Present one command after a random idle gap (none when sender_idles is clear) and hold it until taken.
  task automatic send_cmd(input cmd_t c, input logic [31:0] v);
    int gap;
    gap = sender_idles ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start    <= 1'b1;
    in_cmd   <= c;
    in_value <= v;
    do @(posedge clk); while (busy);
    apply_deque_cmd(c, v);
  endtask

  function automatic cmd_t pick_cmd(input int push_pct);
    bit at_front;
    at_front = $urandom_range(0, 1);
    if ($urandom_range(0, 99) < push_pct)
      return at_front ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
    return at_front ? CMD_POP_FRONT : CMD_POP_BACK;
  endfunction

  // Hold off the sender until every outstanding result is back.
  task automatic wait_results_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result checker: one result per strobe, in command order.
  always @(posedge clk) begin
    deque_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", {30'd0, out_status}, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", {30'd0, out_status}, {30'd0, want.status});
        if (out_popped !== want.popped)
          report_mismatch("popped", out_popped, want.popped);
        if (out_occupancy !== want.occupancy)
          report_mismatch("occupancy", 32'(out_occupancy), 32'(want.occupancy));
      end
    end
  end

  task automatic test_pops_when_empty();
    send_cmd(CMD_POP_FRONT, 32'h7FFF_FFFF);
    send_cmd(CMD_POP_BACK,  32'h8000_0000);
  endtask

  task automatic test_single_entry();
    send_cmd(CMD_PUSH_BACK,  32'h8000_0000);
    send_cmd(CMD_POP_FRONT,  32'hFFFF_FFFF);
    send_cmd(CMD_PUSH_FRONT, 32'h7FFF_FFFF);
    send_cmd(CMD_POP_BACK,   32'h0000_0000);
    send_cmd(CMD_PUSH_BACK,  32'hFFFF_FFFF);
    send_cmd(CMD_POP_BACK,   32'h1234_5678);
    send_cmd(CMD_PUSH_FRONT, 32'h0000_0000);
    send_cmd(CMD_POP_FRONT,  32'hFFFF_FFFF);
  endtask

  task automatic test_both_ends();
    send_cmd(CMD_PUSH_FRONT, 32'h0000_0001);
    send_cmd(CMD_PUSH_BACK,  32'h0000_0002);
    send_cmd(CMD_PUSH_FRONT, 32'hAAAA_AAAA);
    send_cmd(CMD_PUSH_BACK,  32'h5555_5555);
    send_cmd(CMD_POP_FRONT,  32'h0);
    send_cmd(CMD_POP_BACK,   32'h0);
    send_cmd(CMD_POP_FRONT,  32'h0);
    send_cmd(CMD_POP_BACK,   32'h0);
    send_cmd(CMD_POP_FRONT,  32'h0);
  endtask

  task automatic test_random_mix(input int n);
    repeat (n) send_cmd(pick_cmd(50), $urandom);
  endtask

  // Send mostly pushes until full, then keep sending mostly pushes so some are dropped.
  task automatic test_fill_and_overflow();
    while (shadow_fill < DEPTH) send_cmd(pick_cmd(90), $urandom);
    repeat (25) send_cmd(pick_cmd(70), $urandom);
  endtask

  // Send mostly pops until empty, then keep sending mostly pops so some find nothing.
  task automatic test_drain_and_underflow();
    while (shadow_fill > 0) send_cmd(pick_cmd(10), $urandom);
    repeat (25) send_cmd(pick_cmd(30), $urandom);
  endtask

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_cmd         = CMD_PUSH_FRONT;
    in_value       = '0;
    mismatch_count = 0;
    sender_idles   = 1'b1;
    shadow_head    = 0;
    shadow_tail    = 0;
    shadow_fill    = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_pops_when_empty();
    test_single_entry();
    test_both_ends();
    wait_results_drained();

    test_random_mix(100);
    test_fill_and_overflow();
    wait_results_drained();
    test_drain_and_underflow();

    sender_idles = 1'b0;
    test_random_mix(50);
    test_fill_and_overflow();
    sender_idles = 1'b1;
    test_drain_and_underflow();

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/bdq_pkg.sv
rtl/bdq_ram.sv
rtl/bounded_deque_top.sv
bench/bounded_deque_top_tb.sv
